// File: src/cfr_pkg.sv
`default_nettype none

package cfr_pkg;

    localparam int PAYLOAD_WORDS_DEF = 16;
    localparam int BYTE_W            = 8;
    localparam int WORD_W            = 32;
    localparam int WORD_INDEX_W      = 4;
    localparam int CRC_W             = 16;

    localparam logic [BYTE_W-1:0] SYNC_A   = 8'd117;
    localparam logic [BYTE_W-1:0] SYNC_B   = 8'd84;
    localparam logic [CRC_W-1:0]  CRC_POLY = 16'hA001;
    localparam logic [CRC_W-1:0]  CRC_INIT = 16'hFFFF;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CRC,
        S_CRC_END,
        S_CHECK,
        S_EMIT_RD,
        S_EMIT_WAIT,
        S_EMIT_PUSH,
        S_SEARCH,
        S_SEARCH_END,
        S_RESOLVE,
        S_MOVE,
        S_MOVE_END
    } t_state;

    typedef struct packed {
        logic init;
        logic en;
    } t_crc_ctl;

    // Reflected CRC-16 update over one byte, LSB first.
    function automatic logic [CRC_W-1:0] crc16_byte(
        input logic [CRC_W-1:0]  c_in,
        input logic [BYTE_W-1:0] v
    );
        logic [CRC_W-1:0] c;
        c = c_in ^ {{(CRC_W-BYTE_W){1'b0}}, v};
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: src/cfr_frame_ram.sv
`default_nettype none

module cfr_frame_ram #(
    parameter int DEPTH = 68,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [AW-1:0]             i_waddr,
    input  wire logic [cfr_pkg::BYTE_W-1:0] i_wdata,
    input  wire logic [AW-1:0]             i_raddr,
    output logic      [cfr_pkg::BYTE_W-1:0] o_rdata
);

    logic [cfr_pkg::BYTE_W-1:0] r_mem [DEPTH];
    logic [cfr_pkg::BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: src/cfr_crc16.sv
`default_nettype none

module cfr_crc16 (
    input  wire logic                       i_clk,
    input  wire cfr_pkg::t_crc_ctl          i_ctl,
    input  wire logic [cfr_pkg::BYTE_W-1:0] i_byte,
    output logic                            o_zero
);

    logic [cfr_pkg::CRC_W-1:0] r_crc;
    logic [cfr_pkg::CRC_W-1:0] n_crc;

    always_comb begin
        n_crc = r_crc;
        if (i_ctl.init) begin
            n_crc = cfr_pkg::CRC_INIT;
        end else if (i_ctl.en) begin
            n_crc = cfr_pkg::crc16_byte(r_crc, i_byte);
        end
    end

    always_ff @(posedge i_clk) begin
        r_crc <= n_crc;
    end

    assign o_zero = (r_crc == '0);

endmodule

`default_nettype wire

// File: src/calibration_frame_receiver.sv
// Calibration frame receiver.
// Input channel: one byte per request on i_valid / i_rx_byte, taken when
// o_stall is low. Output channel: one payload word per request on o_valid
// with o_word_index, o_word_value and o_last_word, taken when i_stall is low.
// Bytes are stored in a frame RAM with one write and one registered read
// port. A byte that does not complete a frame is taken without raising
// o_stall. The byte that completes a frame starts passes over the RAM:
//   CRC check: reads all FRAME_LEN bytes, one per cycle (FRAME_LEN = 4*PAYLOAD_WORDS + 4).
//   Good frame: then 4 RAM reads per word, and each word waits out any stall.
//   Bad frame: search bytes 2 on for a sync pair, one read per cycle, then
//   move the FRAME_LEN - i tail bytes down when one is found at i.
// o_stall is high for the whole pass. The last word sits in an output
// register, so new bytes are taken while it waits. A stall on the output
// holds the word and pauses the emission. Reset empties the frame and
// drops any pending word; RAM contents need no clearing since a byte is
// always written before it is read.
`default_nettype none

module calibration_frame_receiver #(
    parameter int PAYLOAD_WORDS = cfr_pkg::PAYLOAD_WORDS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    input  wire logic [cfr_pkg::BYTE_W-1:0]       i_rx_byte,
    output logic                                  o_stall,
    output logic                                  o_valid,
    output logic [cfr_pkg::WORD_INDEX_W-1:0]      o_word_index,
    output logic [cfr_pkg::WORD_W-1:0]            o_word_value,
    output logic                                  o_last_word,
    input  wire logic                             i_stall
);

    localparam int FRAME_LEN = 4 * PAYLOAD_WORDS + 4;
    localparam int AW        = $clog2(FRAME_LEN);
    localparam int FW        = $clog2(FRAME_LEN + 1);
    localparam int KW        = $clog2(PAYLOAD_WORDS + 1);
    localparam int BW        = cfr_pkg::BYTE_W;
    localparam int WW        = cfr_pkg::WORD_W;
    localparam int IW        = cfr_pkg::WORD_INDEX_W;

    cfr_pkg::t_state r_state, n_state;

    logic [FW-1:0] r_fill,   n_fill;
    logic [AW-1:0] r_ptr,    n_ptr;
    logic [AW-1:0] r_dst,    n_dst;
    logic [AW-1:0] r_base,   n_base;
    logic [AW-1:0] r_rd_addr, n_rd_addr;
    logic          r_rd_vld, n_rd_vld;
    logic          r_prev_a, n_prev_a;
    logic          r_found,  n_found;
    logic [1:0]    r_b,      n_b;
    logic [KW-1:0] r_k,      n_k;
    logic [WW-1:0] r_acc,    n_acc;

    logic          r_out_valid, n_out_valid;
    logic [IW-1:0] r_out_idx,   n_out_idx;
    logic [WW-1:0] r_out_word,  n_out_word;
    logic          r_out_last,  n_out_last;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [BW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [BW-1:0] ram_rdata;

    cfr_pkg::t_crc_ctl crc_ctl;
    logic              crc_zero;

    logic          in_acc;
    logic          out_free;
    logic [KW+IW-1:0] k_ext;

    cfr_frame_ram #(
        .DEPTH (FRAME_LEN),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    cfr_crc16 u_crc (
        .i_clk  (i_clk),
        .i_ctl  (crc_ctl),
        .i_byte (ram_rdata),
        .o_zero (crc_zero)
    );

    assign in_acc   = i_valid && (r_state == cfr_pkg::S_IDLE);
    assign out_free = !r_out_valid || !i_stall;
    assign k_ext    = {{IW{1'b0}}, r_k};

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_ptr       = r_ptr;
        n_dst       = r_dst;
        n_base      = r_base;
        n_rd_addr   = r_ptr;
        n_rd_vld    = 1'b0;
        n_prev_a    = r_prev_a;
        n_found     = r_found;
        n_b         = r_b;
        n_k         = r_k;
        n_acc       = r_rd_vld ? {ram_rdata, r_acc[WW-1:BW]} : r_acc;
        n_out_valid = r_out_valid && i_stall;
        n_out_idx   = r_out_idx;
        n_out_word  = r_out_word;
        n_out_last  = r_out_last;

        ram_we      = 1'b0;
        ram_waddr   = r_fill[AW-1:0];
        ram_wdata   = i_rx_byte;
        ram_raddr   = r_ptr;

        crc_ctl.init = 1'b0;
        crc_ctl.en   = r_rd_vld && (r_state == cfr_pkg::S_CRC ||
                                    r_state == cfr_pkg::S_CRC_END);

        // Search bookkeeping: track a 117,84 pair and the last byte seen.
        if (r_rd_vld && (r_state == cfr_pkg::S_SEARCH ||
                         r_state == cfr_pkg::S_SEARCH_END)) begin
            if (r_prev_a && ram_rdata == cfr_pkg::SYNC_B && !r_found) begin
                n_found = 1'b1;
                n_base  = r_rd_addr - AW'(1);
            end
            n_prev_a = (ram_rdata == cfr_pkg::SYNC_A);
        end

        // Move: write each byte from the registered read port to the next low slot.
        if (r_rd_vld && (r_state == cfr_pkg::S_MOVE ||
                         r_state == cfr_pkg::S_MOVE_END)) begin
            ram_we    = 1'b1;
            ram_waddr = r_dst;
            ram_wdata = ram_rdata;
            n_dst     = r_dst + AW'(1);
        end

        case (r_state)
            cfr_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (r_fill == FW'(0) && i_rx_byte != cfr_pkg::SYNC_A) begin
                        n_fill = r_fill;
                    end else if (r_fill == FW'(1) && i_rx_byte != cfr_pkg::SYNC_B) begin
                        n_fill = '0;
                    end else begin
                        ram_we = 1'b1;
                        n_fill = r_fill + FW'(1);
                        if (r_fill == FW'(FRAME_LEN - 1)) begin
                            n_ptr        = '0;
                            crc_ctl.init = 1'b1;
                            n_state      = cfr_pkg::S_CRC;
                        end
                    end
                end
            end
            cfr_pkg::S_CRC: begin
                n_rd_vld = 1'b1;
                n_ptr    = r_ptr + AW'(1);
                if (r_ptr == AW'(FRAME_LEN - 1)) begin
                    n_state = cfr_pkg::S_CRC_END;
                end
            end
            cfr_pkg::S_CRC_END: begin
                n_state = cfr_pkg::S_CHECK;
            end
            cfr_pkg::S_CHECK: begin
                n_ptr = AW'(2);
                if (crc_zero) begin
                    n_b     = '0;
                    n_k     = '0;
                    n_state = cfr_pkg::S_EMIT_RD;
                end else begin
                    n_prev_a = 1'b0;
                    n_found  = 1'b0;
                    n_state  = cfr_pkg::S_SEARCH;
                end
            end
            cfr_pkg::S_EMIT_RD: begin
                n_rd_vld = 1'b1;
                n_ptr    = r_ptr + AW'(1);
                n_b      = r_b + 2'd1;
                if (r_b == 2'd3) begin
                    n_state = cfr_pkg::S_EMIT_WAIT;
                end
            end
            cfr_pkg::S_EMIT_WAIT: begin
                n_state = cfr_pkg::S_EMIT_PUSH;
            end
            cfr_pkg::S_EMIT_PUSH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_idx   = k_ext[IW-1:0];
                    n_out_word  = r_acc;
                    n_out_last  = (r_k == KW'(PAYLOAD_WORDS - 1));
                    if (r_k == KW'(PAYLOAD_WORDS - 1)) begin
                        n_fill  = '0;
                        n_state = cfr_pkg::S_IDLE;
                    end else begin
                        n_k     = r_k + KW'(1);
                        n_state = cfr_pkg::S_EMIT_RD;
                    end
                end
            end
            cfr_pkg::S_SEARCH: begin
                n_rd_vld = 1'b1;
                n_ptr    = r_ptr + AW'(1);
                if (r_ptr == AW'(FRAME_LEN - 1)) begin
                    n_state = cfr_pkg::S_SEARCH_END;
                end
            end
            cfr_pkg::S_SEARCH_END: begin
                n_state = cfr_pkg::S_RESOLVE;
            end
            cfr_pkg::S_RESOLVE: begin
                if (r_found) begin
                    n_fill  = FW'(FRAME_LEN) - FW'(r_base);
                    n_ptr   = r_base;
                    n_dst   = '0;
                    n_state = cfr_pkg::S_MOVE;
                end else if (r_prev_a) begin
                    // keep the trailing sync byte as the start of a new frame
                    ram_we    = 1'b1;
                    ram_waddr = '0;
                    ram_wdata = cfr_pkg::SYNC_A;
                    n_fill    = FW'(1);
                    n_state   = cfr_pkg::S_IDLE;
                end else begin
                    n_fill  = '0;
                    n_state = cfr_pkg::S_IDLE;
                end
            end
            cfr_pkg::S_MOVE: begin
                n_rd_vld = 1'b1;
                n_ptr    = r_ptr + AW'(1);
                if (r_ptr == AW'(FRAME_LEN - 1)) begin
                    n_state = cfr_pkg::S_MOVE_END;
                end
            end
            cfr_pkg::S_MOVE_END: begin
                n_state = cfr_pkg::S_IDLE;
            end
            default: begin
                n_fill  = '0;
                n_state = cfr_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cfr_pkg::S_IDLE;
            r_fill      <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr      <= n_ptr;
        r_dst      <= n_dst;
        r_base     <= n_base;
        r_rd_addr  <= n_rd_addr;
        r_prev_a   <= n_prev_a;
        r_found    <= n_found;
        r_b        <= n_b;
        r_k        <= n_k;
        r_acc      <= n_acc;
        r_out_idx  <= n_out_idx;
        r_out_word <= n_out_word;
        r_out_last <= n_out_last;
    end

    assign o_stall      = (r_state != cfr_pkg::S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_word_index = r_out_idx;
    assign o_word_value = r_out_word;
    assign o_last_word  = r_out_last;

endmodule

`default_nettype wire

// File: dv/tb_calibration_frame_receiver.sv
`timescale 1ns / 1ps

module tb_calibration_frame_receiver;

    localparam int FRAME_BYTES = 4 * cfr_pkg::PAYLOAD_WORDS_DEF + 4;
    localparam int NWORDS      = cfr_pkg::PAYLOAD_WORDS_DEF;
    localparam int LONG_HOLD   = 700;
    localparam int END_SETTLE  = 400;
    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASE_BYTES = 60;

    typedef enum {
        SQ_BAD_FIRST,
        SQ_BAD_SECOND,
        SQ_GOOD,
        SQ_BAD_CRC,
        SQ_RESYNC,
        SQ_TRAIL,
        SQ_NOISE
    } t_seq;

    typedef struct {
        t_seq       kind;
        logic [7:0] arg;
        int         pos;
        logic       typed;
    } t_row;

    typedef struct {
        logic [7:0] val;
        logic       typed;
        int         typed_n;
        logic [7:0] fill;
    } t_rx_req;

    typedef struct packed {
        logic [cfr_pkg::WORD_INDEX_W-1:0] idx;
        logic [cfr_pkg::WORD_W-1:0]       val;
        logic                             is_last;
    } t_word;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_valid = 1'b0;
    logic [cfr_pkg::BYTE_W-1:0]        i_rx_byte = '0;
    logic                              i_stall = 1'b0;
    logic                              o_stall;
    logic                              o_valid;
    logic [cfr_pkg::WORD_INDEX_W-1:0]  o_word_index;
    logic [cfr_pkg::WORD_W-1:0]        o_word_value;
    logic                              o_last_word;

    calibration_frame_receiver dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_rx_byte    (i_rx_byte),
        .o_stall      (o_stall),
        .o_valid      (o_valid),
        .o_word_index (o_word_index),
        .o_word_value (o_word_value),
        .o_last_word  (o_last_word),
        .i_stall      (i_stall)
    );

    // Directed sequences; typed rows carry their own expectation.
    t_row steer_rows [8] = '{
        '{SQ_BAD_FIRST,  8'h00,  0, 1'b1},
        '{SQ_BAD_FIRST,  8'hFF,  0, 1'b1},
        '{SQ_BAD_FIRST,  8'd84,  0, 1'b1},
        '{SQ_BAD_SECOND, 8'h00,  0, 1'b1},
        '{SQ_BAD_SECOND, 8'd117, 0, 1'b1},
        '{SQ_BAD_SECOND, 8'hFF,  0, 1'b1},
        '{SQ_GOOD,       8'hFF,  0, 1'b1},
        '{SQ_RESYNC,     8'h00,  2, 1'b0}
    };

    logic [7:0] shadow_frame [FRAME_BYTES];
    int         shadow_fill = 0;
    t_word      fresh_words [$];
    t_word      pending_words [$];
    t_rx_req    byte_q [$];
    t_rx_req    cur_req;
    t_word      want;

    logic [7:0] good_frame [FRAME_BYTES];
    logic [7:0] bad_frame [FRAME_BYTES];

    int   src_idle_pct = 0;
    int   sink_stall_pct = 0;
    int   counted_bytes = 0;
    int   err_cnt = 0;
    int   cycle_cnt = 0;
    int   hold_left = 0;
    logic hold_tog = 1'b0;
    logic hold_seen = 1'b0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Reflected CRC-16, one bit at a time.
    function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] v);
        logic [15:0] r;
        logic        fb;
        r = c;
        for (int b = 0; b < 8; b++) begin
            fb = r[0] ^ v[b];
            r  = r >> 1;
            if (fb) begin
                r = r ^ cfr_pkg::CRC_POLY;
            end
        end
        return r;
    endfunction

    // Advance the frame shadow by one accepted byte; words land in fresh_words.
    function automatic void frame_accept(input logic [7:0] v);
        logic [15:0] rem;
        logic [31:0] w;
        int          at;
        if (shadow_fill == 0 && v != cfr_pkg::SYNC_A) begin
            return;
        end
        if (shadow_fill == 1 && v != cfr_pkg::SYNC_B) begin
            shadow_fill = 0;
            return;
        end
        shadow_frame[shadow_fill] = v;
        shadow_fill++;
        if (shadow_fill < FRAME_BYTES) begin
            return;
        end
        rem = cfr_pkg::CRC_INIT;
        for (int n = 0; n < FRAME_BYTES; n++) begin
            rem = crc_step(rem, shadow_frame[n]);
        end
        if (rem == 16'h0000) begin
            for (int k = 0; k < NWORDS; k++) begin
                at = 2 + 4 * k;
                w  = {shadow_frame[at+3], shadow_frame[at+2],
                      shadow_frame[at+1], shadow_frame[at]};
                fresh_words.push_back('{4'(k), w, (k == NWORDS - 1)});
            end
            shadow_fill = 0;
            return;
        end
        // resync on the lowest sync pair past the header
        for (int n = 2; n + 1 < FRAME_BYTES; n++) begin
            if (shadow_frame[n] == cfr_pkg::SYNC_A && shadow_frame[n+1] == cfr_pkg::SYNC_B) begin
                shadow_fill = FRAME_BYTES - n;
                for (int m = 0; m < shadow_fill; m++) begin
                    shadow_frame[m] = shadow_frame[m+n];
                end
                return;
            end
        end
        if (shadow_frame[FRAME_BYTES-1] == cfr_pkg::SYNC_A) begin
            shadow_frame[0] = cfr_pkg::SYNC_A;
            shadow_fill     = 1;
        end else begin
            shadow_fill = 0;
        end
    endfunction

    function automatic logic [7:0] rand_byte();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10) return 8'h00;
        if (pick < 20) return 8'hFF;
        if (pick < 25) return cfr_pkg::SYNC_A;
        if (pick < 30) return cfr_pkg::SYNC_B;
        return 8'($urandom_range(0, 255));
    endfunction

    // Build a frame with a valid CRC, constant or random payload.
    function automatic void make_frame(input logic const_fill, input logic [7:0] fill);
        logic [15:0] c;
        good_frame[0] = cfr_pkg::SYNC_A;
        good_frame[1] = cfr_pkg::SYNC_B;
        for (int n = 2; n < FRAME_BYTES - 2; n++) begin
            good_frame[n] = const_fill ? fill : rand_byte();
        end
        c = cfr_pkg::CRC_INIT;
        for (int n = 0; n < FRAME_BYTES - 2; n++) begin
            c = crc_step(c, good_frame[n]);
        end
        good_frame[FRAME_BYTES-2] = c[7:0];
        good_frame[FRAME_BYTES-1] = c[15:8];
    endfunction

    function automatic void offer(input logic [7:0] v, input logic typed,
                                  input int typed_n, input logic [7:0] fill);
        t_rx_req r;
        r.val     = v;
        r.typed   = typed;
        r.typed_n = typed_n;
        r.fill    = fill;
        byte_q.push_back(r);
    endfunction

    function automatic void queue_sequence(input t_seq kind, input logic [7:0] arg,
                                           input int pos, input logic typed);
        int at;
        case (kind)
            SQ_BAD_FIRST: begin
                offer(arg, typed, 0, arg);
            end
            SQ_BAD_SECOND: begin
                offer(cfr_pkg::SYNC_A, typed, 0, arg);
                offer(arg, typed, 0, arg);
                counted_bytes += 2;
            end
            SQ_GOOD: begin
                make_frame(typed, arg);
                for (int n = 0; n < FRAME_BYTES; n++) begin
                    offer(good_frame[n], typed, (n == FRAME_BYTES - 1) ? NWORDS : 0, arg);
                end
                counted_bytes += FRAME_BYTES;
            end
            SQ_BAD_CRC: begin
                make_frame(typed, arg);
                if (typed) begin
                    // zero the CRC bytes (low byte 01 if both are zero already): no sync pair, no trailing sync
                    if (good_frame[FRAME_BYTES-2] == 8'h00 && good_frame[FRAME_BYTES-1] == 8'h00) begin
                        good_frame[FRAME_BYTES-2] = 8'h01;
                    end else begin
                        good_frame[FRAME_BYTES-2] = 8'h00;
                        good_frame[FRAME_BYTES-1] = 8'h00;
                    end
                end else begin
                    at = $urandom_range(2, FRAME_BYTES - 1);
                    good_frame[at] = good_frame[at] ^ (8'h01 << $urandom_range(0, 7));
                end
                for (int n = 0; n < FRAME_BYTES; n++) begin
                    offer(good_frame[n], typed, 0, arg);
                end
                counted_bytes += FRAME_BYTES;
            end
            SQ_RESYNC: begin
                // corrupt frame whose tail is the head of a good one, then finish it
                make_frame(1'b0, 8'h00);
                bad_frame[0] = cfr_pkg::SYNC_A;
                bad_frame[1] = cfr_pkg::SYNC_B;
                for (int n = 2; n < pos; n++) begin
                    bad_frame[n] = rand_byte();
                end
                for (int n = pos; n < FRAME_BYTES; n++) begin
                    bad_frame[n] = good_frame[n-pos];
                end
                for (int n = 0; n < FRAME_BYTES; n++) begin
                    offer(bad_frame[n], 1'b0, 0, 8'h00);
                end
                for (int n = FRAME_BYTES - pos; n < FRAME_BYTES; n++) begin
                    offer(good_frame[n], 1'b0, 0, 8'h00);
                end
                counted_bytes += FRAME_BYTES + pos;
            end
            SQ_TRAIL: begin
                make_frame(1'b0, 8'h00);
                bad_frame[0] = cfr_pkg::SYNC_A;
                bad_frame[1] = cfr_pkg::SYNC_B;
                for (int n = 2; n < FRAME_BYTES - 1; n++) begin
                    bad_frame[n] = rand_byte();
                end
                bad_frame[FRAME_BYTES-1] = cfr_pkg::SYNC_A;
                for (int n = 0; n < FRAME_BYTES; n++) begin
                    offer(bad_frame[n], 1'b0, 0, 8'h00);
                end
                for (int n = 1; n < FRAME_BYTES; n++) begin
                    offer(good_frame[n], 1'b0, 0, 8'h00);
                end
                counted_bytes += 2 * FRAME_BYTES - 1;
            end
            default: begin
                at = $urandom_range(1, 4);
                for (int n = 0; n < at; n++) begin
                    offer(rand_byte(), 1'b0, 0, 8'h00);
                end
            end
        endcase
    endfunction

    function automatic void queue_random_sequence();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            queue_sequence(SQ_GOOD, 8'h00, 0, 1'b0);
        end else if (pick < 70) begin
            queue_sequence(SQ_BAD_CRC, 8'h00, 0, 1'b0);
        end else if (pick < 80) begin
            queue_sequence(SQ_RESYNC, 8'h00, $urandom_range(2, FRAME_BYTES - 2), 1'b0);
        end else if (pick < 88) begin
            queue_sequence(SQ_TRAIL, 8'h00, 0, 1'b0);
        end else if (pick < 95) begin
            queue_sequence(SQ_NOISE, 8'h00, 0, 1'b0);
        end else begin
            queue_sequence(SQ_BAD_SECOND, rand_byte(), 0, 1'b0);
        end
    endfunction

    // Byte sender: predict on each accepted request, then offer the next one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid     <= 1'b0;
            shadow_fill = 0;
        end else begin
            if (i_valid && !o_stall) begin
                fresh_words.delete();
                frame_accept(cur_req.val);
                if (cur_req.typed) begin
                    for (int k = 0; k < cur_req.typed_n; k++) begin
                        pending_words.push_back('{4'(k), {4{cur_req.fill}},
                                                  (k == cur_req.typed_n - 1)});
                    end
                end else begin
                    foreach (fresh_words[k]) begin
                        pending_words.push_back(fresh_words[k]);
                    end
                end
            end
            if (!i_valid || !o_stall) begin
                if (byte_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    cur_req = byte_q.pop_front();
                    i_valid   <= 1'b1;
                    i_rx_byte <= cur_req.val;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Word receiver stall, with a long hold-off each time hold_tog toggles.
    always @(posedge i_clk) begin
        if (hold_tog != hold_seen) begin
            hold_seen = hold_tog;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected word: index %0d value %h last %b",
                         $time, o_word_index, o_word_value, o_last_word);
                err_cnt++;
            end else begin
                want = pending_words.pop_front();
                if (o_word_index !== want.idx) begin
                    $display("%0t: word_index expected %0d actual %0d",
                             $time, want.idx, o_word_index);
                    err_cnt++;
                end
                if (o_word_value !== want.val) begin
                    $display("%0t: word_value expected %h actual %h",
                             $time, want.val, o_word_value);
                    err_cnt++;
                end
                if (o_last_word !== want.is_last) begin
                    $display("%0t: last_word expected %b actual %b",
                             $time, want.is_last, o_last_word);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d words still expected", $time, pending_words.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic drain();
        while (byte_q.size() != 0 || i_valid || pending_words.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        src_idle_pct   <= 36;
        sink_stall_pct <= 36;
        foreach (steer_rows[r]) begin
            queue_sequence(steer_rows[r].kind, steer_rows[r].arg,
                           steer_rows[r].pos, steer_rows[r].typed);
        end
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            counted_bytes = 0;
            case (ph)
                0: begin src_idle_pct <= 0;  sink_stall_pct <= 0;  end
                1: begin src_idle_pct <= 67; sink_stall_pct <= 0;  end
                default: begin src_idle_pct <= 0; sink_stall_pct <= 67; end
            endcase
            if (ph == 0) begin
                // hold the output off while a good frame and more bytes keep arriving
                hold_tog <= ~hold_tog;
                queue_sequence(SQ_GOOD, 8'h00, 0, 1'b0);
                queue_sequence(SQ_BAD_SECOND, 8'h00, 0, 1'b0);
            end
            while (counted_bytes < PHASE_BYTES) begin
                queue_random_sequence();
            end
            drain();
        end

        repeat (END_SETTLE) @(posedge i_clk);
        if (err_cnt == 0 && pending_words.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/cfr_pkg.sv
src/cfr_frame_ram.sv
src/cfr_crc16.sv
src/calibration_frame_receiver.sv
dv/tb_calibration_frame_receiver.sv
